FILE: rtl/nec_ir_remote_decoder_unit_assert.svh
// assertion macros for the decoder top module
// no dependencies; sampled on clk_i, with rst_ni as the disable of NIRD_ASSERT only
`ifndef NEC_IR_REMOTE_DECODER_UNIT_ASSERT_SVH
`define NEC_IR_REMOTE_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define NIRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define NIRD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define NIRD_ASSERT(lbl, prop, msg)
`define NIRD_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: rtl/nird_pkg.sv
// types, register indexes, status codes and key table of the nec ir decoder
// no dependencies
`default_nettype none

package nird_pkg;

  localparam int TickW    = 16;
  localparam int WordW    = 32;
  localparam int CmdW     = 8;
  localparam int StatusW  = 2;
  localparam int CfgIdxW  = 2;
  localparam int CountW   = 5;
  localparam int KeyCount = 18;

  localparam logic [CfgIdxW-1:0] REG_LEADER_MIN = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ONE_MIN    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ZERO_MIN   = 2'd2;

  localparam logic [TickW-1:0] LEADER_MIN_RST = 16'd8000;
  localparam logic [TickW-1:0] ONE_MIN_RST    = 16'd1700;
  localparam logic [TickW-1:0] ZERO_MIN_RST   = 16'd1000;

  localparam logic [StatusW-1:0] STATUS_NONE    = 2'd0;
  localparam logic [StatusW-1:0] STATUS_KNOWN   = 2'd1;
  localparam logic [StatusW-1:0] STATUS_UNKNOWN = 2'd2;
  localparam logic [StatusW-1:0] STATUS_BADCHK  = 2'd3;

  localparam logic [CmdW-1:0] CMD_NONE = 8'h00;

  localparam logic [WordW-1:0] KEY_CODE [KeyCount] = '{
    32'h00FFA25D, 32'h00FF629D, 32'h00FFE21D, 32'h00FF22DD, 32'h00FF02FD, 32'h00FFC23D,
    32'h00FFE01F, 32'h00FFA857, 32'h00FF906F, 32'h00FFB04F, 32'h00FF6897, 32'h00FF9867,
    32'h00FF38C7, 32'h00FF18E7, 32'h00FF10EF, 32'h00FF5AA5, 32'h00FF4AB5, 32'h00FF30CF
  };

  // ascii F L S R B H G T, zero for keys without action
  localparam logic [CmdW-1:0] KEY_CHAR [KeyCount] = '{
    8'h00, 8'h46, 8'h00, 8'h4C, 8'h53, 8'h52,
    8'h00, 8'h42, 8'h00, 8'h00, 8'h00, 8'h48,
    8'h47, 8'h00, 8'h00, 8'h00, 8'h00, 8'h54
  };

  typedef struct packed {
    logic [TickW-1:0] leader_min;
    logic [TickW-1:0] one_min;
    logic [TickW-1:0] zero_min;
  } thresh_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] word;
  } frame_t;

endpackage

`default_nettype wire

FILE: rtl/nec_ir_remote_decoder_unit.sv
// nec ir remote decoder top: config registers, input and result registers
// depends on nird_pkg, nird_frame, nird_keymap and the assertion macro header
//
// usage
//   in channel: one item per falling edge of the ir receiver, carrying the
//   tick count since the previous edge. out channel: one item per input
//   item with status, command character and completed frame word.
//   config channel: cfg_index_i selects leader (0), one (1) or zero (2)
//   threshold; other indexes are dropped. cfg_ready_o is always high.
//   an accepted item is held in the input register and moves through
//   classify, shift and table match into the result register.
//   throughput: one item per cycle while the out channel does not stall,
//   set by the single input register.
//   reset: thresholds return to 8000/1700/1000, frame word and bit count
//   clear, both channels come up empty.
//   stall: a held result keeps its register; one more item waits in the
//   input register, then in_ready_o drops until the result is taken.
`default_nettype none
`include "nec_ir_remote_decoder_unit_assert.svh"

module nec_ir_remote_decoder_unit
  import nird_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [TickW-1:0]    cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [TickW-1:0]    edge_interval_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [StatusW-1:0]       frame_status_o,
  output logic [CmdW-1:0]          key_command_o,
  output logic [WordW-1:0]         frame_word_o
);

  thresh_t           thresh_q;
  logic              in_valid_q;
  logic [TickW-1:0]  interval_q;
  logic              out_valid_q;
  logic [StatusW-1:0] status_q, status_d;
  logic [CmdW-1:0]   cmd_q, cmd_d;
  logic [WordW-1:0]  word_q, word_d;
  logic              advance;
  logic              in_fire;
  frame_t            frame;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign in_fire     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q.leader_min <= LEADER_MIN_RST;
      thresh_q.one_min    <= ONE_MIN_RST;
      thresh_q.zero_min   <= ZERO_MIN_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LEADER_MIN: thresh_q.leader_min <= cfg_data_i;
        REG_ONE_MIN:    thresh_q.one_min    <= cfg_data_i;
        REG_ZERO_MIN:   thresh_q.zero_min   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      interval_q <= edge_interval_i;
    end
  end

  nird_frame u_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .interval_i (interval_q),
    .thresh_i   (thresh_q),
    .frame_o    (frame)
  );

  nird_keymap u_keymap (
    .frame_i  (frame),
    .status_o (status_d),
    .cmd_o    (cmd_d),
    .word_o   (word_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q <= status_d;
      cmd_q    <= cmd_d;
      word_q   <= word_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_status_o = status_q;
  assign key_command_o  = cmd_q;
  assign frame_word_o   = word_q;

  `NIRD_ASSERT(a_cmd_only_known,
    out_valid_o && (frame_status_o != STATUS_KNOWN) |-> key_command_o == CMD_NONE,
    "command set without a known key")
  `NIRD_ASSERT(a_word_only_done,
    out_valid_o && (frame_status_o == STATUS_NONE) |-> frame_word_o == '0,
    "frame word set without a completed frame")
  `NIRD_ASSERT(a_stall_cause,
    !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i,
    "input stalled while the result side can move")
  `NIRD_ASSERT(a_accept_loads,
    in_valid_i && in_ready_o |=> in_valid_q,
    "accepted item not held in the input register")

endmodule

`default_nettype wire

FILE: rtl/nird_frame.sv
// interval classifier and frame shift register with bit counter
// depends on nird_pkg
`default_nettype none

module nird_frame
  import nird_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [TickW-1:0] interval_i,
  input  wire thresh_t          thresh_i,
  output frame_t                frame_o
);

  logic [WordW-1:0]  word_q, word_d;
  logic [CountW-1:0] count_q, count_d;
  logic              is_leader, is_one, is_zero;

  assign is_leader = interval_i > thresh_i.leader_min;
  assign is_one    = !is_leader && (interval_i > thresh_i.one_min);
  assign is_zero   = !is_leader && !is_one && (interval_i > thresh_i.zero_min);

  always_comb begin
    word_d       = word_q;
    count_d      = count_q;
    frame_o.done = 1'b0;
    if (is_leader) begin
      word_d  = '0;
      count_d = '0;
    end else if (is_one || is_zero) begin
      // first bit lands in the msb
      word_d[~count_q] = is_one;
      count_d          = count_q + CountW'(1);
      frame_o.done     = &count_q;
    end
    frame_o.word = word_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q  <= '0;
      count_q <= '0;
    end else if (step_i) begin
      word_q  <= word_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/nird_keymap.sv
// frame check and key table match for a completed frame
// depends on nird_pkg
`default_nettype none

module nird_keymap
  import nird_pkg::*;
(
  input  wire frame_t             frame_i,
  output logic [StatusW-1:0]      status_o,
  output logic [CmdW-1:0]         cmd_o,
  output logic [WordW-1:0]        word_o
);

  logic            check_ok;
  logic            hit;
  logic [CmdW-1:0] hit_cmd;

  assign check_ok = (~frame_i.word[7:0]) == frame_i.word[15:8];

  always_comb begin
    hit     = 1'b0;
    hit_cmd = CMD_NONE;
    for (int i = KeyCount - 1; i >= 0; i--) begin
      if (frame_i.word == KEY_CODE[i]) begin
        hit     = 1'b1;
        hit_cmd = KEY_CHAR[i];
      end
    end
  end

  always_comb begin
    status_o = STATUS_NONE;
    cmd_o    = CMD_NONE;
    word_o   = '0;
    if (frame_i.done) begin
      word_o = frame_i.word;
      if (!check_ok) begin
        status_o = STATUS_BADCHK;
      end else if (hit) begin
        status_o = STATUS_KNOWN;
        cmd_o    = hit_cmd;
      end else begin
        status_o = STATUS_UNKNOWN;
      end
    end
  end

endmodule

`default_nettype wire

FILE: bench/tb_nec_ir_remote_decoder_unit.sv
`timescale 1ns / 1ps
// testbench for nec_ir_remote_decoder_unit: a directed table of edges and frames, then
// random edges and ir frames under several threshold settings; items are checked against
// a model, tagged rows against the table; depends on nird_pkg and the decoder rtl

module tb_nec_ir_remote_decoder_unit;
  import nird_pkg::*;

  localparam int RunLimit = 400000;
  localparam int KeyTotal = 18;
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {CLS_IGN, CLS_ZERO, CLS_ONE, CLS_LEAD} edge_cls_e;
  typedef enum logic [1:0] {ROW_EDGE, ROW_FRAME, ROW_BARE} row_kind_e;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CmdW-1:0]    cmd;
    logic [WordW-1:0]   word;
  } ir_result_t;

  typedef struct packed {
    row_kind_e        kind;
    logic [WordW-1:0] value;
    logic             typed;
    ir_result_t       want;
  } dir_row_t;

  localparam logic [WordW-1:0] REMOTE_CODES [KeyTotal] = '{
    32'h00FFA25D, 32'h00FF629D, 32'h00FFE21D, 32'h00FF22DD, 32'h00FF02FD, 32'h00FFC23D,
    32'h00FFE01F, 32'h00FFA857, 32'h00FF906F, 32'h00FFB04F, 32'h00FF6897, 32'h00FF9867,
    32'h00FF38C7, 32'h00FF18E7, 32'h00FF10EF, 32'h00FF5AA5, 32'h00FF4AB5, 32'h00FF30CF
  };

  localparam logic [CmdW-1:0] REMOTE_CHARS [KeyTotal] = '{
    8'h00, "F", 8'h00, "L", "S", "R", 8'h00, "B", 8'h00,
    8'h00, 8'h00, "H", "G", 8'h00, 8'h00, 8'h00, 8'h00, "T"
  };

  localparam dir_row_t DIR_ROWS [16] = '{
    '{ROW_EDGE,  32'd0,        1'b1, '{STATUS_NONE,    CMD_NONE, 32'h0}},
    '{ROW_EDGE,  32'd65535,    1'b1, '{STATUS_NONE,    CMD_NONE, 32'h0}},
    '{ROW_EDGE,  32'd1000,     1'b0, '{STATUS_NONE,    CMD_NONE, 32'h0}},
    '{ROW_EDGE,  32'd1001,     1'b0, '{STATUS_NONE,    CMD_NONE, 32'h0}},
    '{ROW_EDGE,  32'd1700,     1'b0, '{STATUS_NONE,    CMD_NONE, 32'h0}},
    '{ROW_EDGE,  32'd1701,     1'b0, '{STATUS_NONE,    CMD_NONE, 32'h0}},
    '{ROW_EDGE,  32'd8000,     1'b0, '{STATUS_NONE,    CMD_NONE, 32'h0}},
    '{ROW_EDGE,  32'd8001,     1'b0, '{STATUS_NONE,    CMD_NONE, 32'h0}},
    '{ROW_FRAME, 32'h00FF629D, 1'b1, '{STATUS_KNOWN,   "F",      32'h00FF629D}},
    '{ROW_FRAME, 32'h00FFA25D, 1'b1, '{STATUS_KNOWN,   CMD_NONE, 32'h00FFA25D}},
    '{ROW_FRAME, 32'h00FF00FF, 1'b1, '{STATUS_UNKNOWN, CMD_NONE, 32'h00FF00FF}},
    '{ROW_FRAME, 32'h12345678, 1'b1, '{STATUS_BADCHK,  CMD_NONE, 32'h12345678}},
    '{ROW_FRAME, 32'hFFFFFF00, 1'b1, '{STATUS_UNKNOWN, CMD_NONE, 32'hFFFFFF00}},
    '{ROW_FRAME, 32'h00000000, 1'b1, '{STATUS_BADCHK,  CMD_NONE, 32'h00000000}},
    '{ROW_BARE,  32'h00FF30CF, 1'b1, '{STATUS_KNOWN,   "T",      32'h00FF30CF}},
    '{ROW_BARE,  32'h00FF22DD, 1'b1, '{STATUS_KNOWN,   "L",      32'h00FF22DD}}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [TickW-1:0]   cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [TickW-1:0]   edge_interval_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [StatusW-1:0] frame_status_o;
  logic [CmdW-1:0]    key_command_o;
  logic [WordW-1:0]   frame_word_o;

  // model state
  logic [TickW-1:0] lead_thr, one_thr, zero_thr;
  logic [WordW-1:0] rx_word;
  logic [5:0]       rx_bits;

  ir_result_t frame_results_q [$];
  logic       in_fire_seen, out_fire_seen, cfg_fire_seen;
  logic       tag_en = 1'b0;
  ir_result_t tag_want = '0;
  bit         idle_off = 1'b0;
  int         noise_pct = 0;
  int         edges_used = 0;
  int         err_cnt = 0;
  int         cycle_cnt = 0;

  nec_ir_remote_decoder_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .edge_interval_i (edge_interval_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frame_status_o  (frame_status_o),
    .key_command_o   (key_command_o),
    .frame_word_o    (frame_word_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic edge_cls_e classify(input logic [TickW-1:0] iv);
    if (iv > lead_thr) return CLS_LEAD;
    if (iv > one_thr) return CLS_ONE;
    if (iv > zero_thr) return CLS_ZERO;
    return CLS_IGN;
  endfunction

  function automatic ir_result_t decode_edge(input logic [TickW-1:0] iv);
    ir_result_t r;
    logic       hit;
    int         i;
    r = '0;
    hit = 1'b0;
    case (classify(iv))
      CLS_LEAD: begin
        rx_word = '0;
        rx_bits = '0;
      end
      CLS_ONE: begin
        rx_word[5'd31 - rx_bits[4:0]] = 1'b1;
        rx_bits = rx_bits + 6'd1;
      end
      CLS_ZERO: begin
        rx_word[5'd31 - rx_bits[4:0]] = 1'b0;
        rx_bits = rx_bits + 6'd1;
      end
      default: ;
    endcase
    if (rx_bits >= 6'd32) begin
      r.word = rx_word;
      if (~rx_word[7:0] == rx_word[15:8]) begin
        r.status = STATUS_UNKNOWN;
        for (i = 0; i < KeyTotal; i++) begin
          if (!hit && REMOTE_CODES[i] == rx_word) begin
            hit = 1'b1;
            r.status = STATUS_KNOWN;
            r.cmd = REMOTE_CHARS[i];
          end
        end
      end else begin
        r.status = STATUS_BADCHK;
      end
      rx_bits = '0;
    end
    return r;
  endfunction

  // random interval in the given class under the current thresholds, any value if none fits
  function automatic logic [TickW-1:0] pick_interval(input edge_cls_e c);
    int lo, hi, m;
    m = (int'(lead_thr) < int'(one_thr)) ? int'(lead_thr) : int'(one_thr);
    case (c)
      CLS_LEAD: begin
        lo = int'(lead_thr) + 1;
        hi = 65535;
      end
      CLS_ONE: begin
        lo = int'(one_thr) + 1;
        hi = int'(lead_thr);
      end
      CLS_ZERO: begin
        lo = int'(zero_thr) + 1;
        hi = m;
      end
      default: begin
        lo = 0;
        hi = (m < int'(zero_thr)) ? m : int'(zero_thr);
      end
    endcase
    if (lo > hi) return 16'($urandom_range(65535, 0));
    case ($urandom_range(3, 0))
      0: return 16'(lo);
      1: return 16'(hi);
      default: return 16'($urandom_range(hi, lo));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_cnt < 40) $display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ir_result_t exp_res, pred;
    if (!rst_ni) begin
      lead_thr = 16'd8000;
      one_thr = 16'd1700;
      zero_thr = 16'd1000;
      rx_word = '0;
      rx_bits = '0;
      in_fire_seen = 1'b0;
      out_fire_seen = 1'b0;
      cfg_fire_seen = 1'b0;
    end else begin
      cycle_cnt++;
      in_fire_seen = in_valid_i && in_ready_o;
      out_fire_seen = out_valid_o && out_ready_i;
      cfg_fire_seen = cfg_valid_i && cfg_ready_o;
      if (cfg_fire_seen) begin
        case (cfg_index_i)
          REG_LEADER_MIN: lead_thr = cfg_data_i;
          REG_ONE_MIN:    one_thr = cfg_data_i;
          REG_ZERO_MIN:   zero_thr = cfg_data_i;
          default: ;
        endcase
      end
      if (out_fire_seen) begin
        if (frame_results_q.size() == 0) begin
          report_mismatch("unexpected item word", frame_word_o, '0);
        end else begin
          exp_res = frame_results_q.pop_front();
          if (frame_status_o !== exp_res.status)
            report_mismatch("frame_status", 32'(frame_status_o), 32'(exp_res.status));
          if (key_command_o !== exp_res.cmd)
            report_mismatch("key_command", 32'(key_command_o), 32'(exp_res.cmd));
          if (frame_word_o !== exp_res.word)
            report_mismatch("frame_word", frame_word_o, exp_res.word);
        end
      end
      if (in_fire_seen) begin
        pred = decode_edge(edge_interval_i);
        frame_results_q.push_back(tag_en ? tag_want : pred);
      end
    end
  end

  initial begin
    wait (cycle_cnt >= RunLimit);
    $display("** nec_ir_remote_decoder_unit: FAILED **");
    $finish;
  end

  // result side back-pressure
  initial begin
    int gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = idle_off ? 0 : $urandom_range(8, 0);
      if (gap != 0) begin
        out_ready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(negedge clk_i); while (!out_fire_seen);
    end
  end

  task automatic send_item(input logic [TickW-1:0] iv, input logic typed,
                           input ir_result_t want);
    int gap;
    gap = idle_off ? 0 : $urandom_range(8, 0);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    edge_interval_i = iv;
    tag_en = typed;
    tag_want = want;
    if (classify(iv) != CLS_IGN) edges_used++;
    do @(negedge clk_i); while (!in_fire_seen);
  endtask

  task automatic send_frame(input logic [WordW-1:0] w, input bit lead, input int nbits,
                            input logic typed, input ir_result_t want);
    ir_result_t none;
    int         i;
    none = '0;
    if (lead) send_item(pick_interval(CLS_LEAD), 1'b0, none);
    for (i = 0; i < nbits; i++) begin
      if ($urandom_range(99, 0) < noise_pct) send_item(pick_interval(CLS_IGN), 1'b0, none);
      send_item(pick_interval(w[31-i] ? CLS_ONE : CLS_ZERO), typed && (i == 31), want);
    end
  endtask

  task automatic random_frame();
    logic [WordW-1:0] w;
    logic [7:0]       b;
    int               r;
    ir_result_t       none;
    none = '0;
    r = $urandom_range(99, 0);
    b = 8'($urandom);
    if (r < 45) w = REMOTE_CODES[$urandom_range(KeyTotal - 1, 0)];
    else if (r < 75) w = {8'($urandom), 8'($urandom), ~b, b};
    else w = $urandom;
    send_frame(w, $urandom_range(9, 0) != 0,
               ($urandom_range(9, 0) == 0) ? int'($urandom_range(31, 1)) : 32, 1'b0, none);
  endtask

  task automatic settle();
    in_valid_i = 1'b0;
    while (frame_results_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [TickW-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(negedge clk_i); while (!cfg_fire_seen);
  endtask

  task automatic set_thresholds(input logic [TickW-1:0] lead, input logic [TickW-1:0] one,
                                input logic [TickW-1:0] zero, input bit poke_unused);
    settle();
    cfg_write(REG_LEADER_MIN, lead);
    cfg_write(REG_ONE_MIN, one);
    cfg_write(REG_ZERO_MIN, zero);
    if (poke_unused) cfg_write(REG_UNUSED, 16'($urandom));
    cfg_valid_i = 1'b0;
  endtask

  task automatic run_phase(input int target, input int noise);
    int         pick, total;
    ir_result_t none;
    none = '0;
    total = 0;
    edges_used = 0;
    noise_pct = noise;
    while (edges_used < target && total < target * 4) begin
      idle_off = ($urandom_range(3, 0) == 0);
      pick = $urandom_range(99, 0);
      total++;
      if (pick < 5) send_item(16'($urandom_range(65535, 0)), 1'b0, none);
      else if (pick < 9) send_item(pick_interval(CLS_LEAD), 1'b0, none);
      else begin
        random_frame();
        total += 32;
      end
    end
    idle_off = 1'b0;
  endtask

  initial begin
    int             i;
    logic [TickW-1:0] z, o;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    for (i = 0; i < $size(DIR_ROWS); i++) begin
      case (DIR_ROWS[i].kind)
        ROW_EDGE:  send_item(DIR_ROWS[i].value[15:0], DIR_ROWS[i].typed, DIR_ROWS[i].want);
        ROW_FRAME: send_frame(DIR_ROWS[i].value, 1'b1, 32, DIR_ROWS[i].typed,
                              DIR_ROWS[i].want);
        default:   send_frame(DIR_ROWS[i].value, 1'b0, 32, DIR_ROWS[i].typed,
                              DIR_ROWS[i].want);
      endcase
    end

    set_thresholds(16'd8000, 16'd1700, 16'd1000, 1'b0);
    run_phase(130, 10);
    set_thresholds(16'd65534, 16'd30000, 16'd0, 1'b0);
    run_phase(130, 10);
    set_thresholds(16'd65535, 16'd65534, 16'd65533, 1'b1);
    run_phase(100, 10);
    set_thresholds(16'd0, 16'd0, 16'd0, 1'b0);
    run_phase(70, 10);
    // inverted order, leader compare wins
    set_thresholds(16'd100, 16'd200, 16'd300, 1'b0);
    run_phase(100, 10);
    repeat (2) begin
      z = 16'($urandom_range(3000, 0));
      o = z + 16'($urandom_range(3000, 1));
      set_thresholds(o + 16'($urandom_range(20000, 1)), o, z, 1'b0);
      run_phase(130, 15);
    end
    set_thresholds(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
    run_phase(100, 10);
    set_thresholds(16'd8000, 16'd1700, 16'd1000, 1'b1);
    run_phase(140, 5);

    settle();
    repeat (4) @(negedge clk_i);
    if (frame_results_q.size() != 0)
      report_mismatch("leftover items", 32'(frame_results_q.size()), '0);
    if (err_cnt == 0) begin
      $display("** nec_ir_remote_decoder_unit: PASSED **");
    end else begin
      $display("** nec_ir_remote_decoder_unit: FAILED **");
    end
    $finish;
  end

endmodule
